// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

// ===== rtl/plsp_pkg.sv =====
// Shared constants and control types of the port list parser.
`timescale 1ns / 1ps
package plsp_pkg;
   localparam int LIST_DEPTH = 1024;
   localparam int PORT_BITS  = 16;
   localparam int LIST_AW    = $clog2(LIST_DEPTH);
   localparam int ACC_W      = PORT_BITS + 1;
   localparam int ROW_BITS   = 6;
   localparam int ROW_W      = 2 ** ROW_BITS;
   localparam int ROW_AW     = PORT_BITS - ROW_BITS;
   localparam int CNT_W      = 16;
   localparam int MAXP_W     = 11;

   localparam logic [3:0] ST_OK       = 4'd0;
   localparam logic [3:0] ST_EMPTY    = 4'd1;
   localparam logic [3:0] ST_TWO_DASH = 4'd2;
   localparam logic [3:0] ST_BAD_CHAR = 4'd3;
   localparam logic [3:0] ST_ZERO     = 4'd4;
   localparam logic [3:0] ST_OVER     = 4'd5;
   localparam logic [3:0] ST_EDGE     = 4'd6;
   localparam logic [3:0] ST_BACKWARD = 4'd7;
   localparam logic [3:0] ST_DUP      = 4'd8;
   localparam logic [3:0] ST_TOO_MANY = 4'd9;

   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [ACC_W-1:0] ACC_SAT = ACC_W'(2 ** PORT_BITS);

   typedef struct packed {
      logic take_in;
      logic fresh;
      logic take_char;
      logic check;
      logic bm_read;
      logic bm_update;
      logic emit;
      logic clr_row;
   } cmd_type;

   typedef struct packed {
      logic is_func1;
      logic is_sep;
      logic is_term;
      logic spec_ended;
      logic walk_go;
      logic bm_hit;
      logic walk_last;
      logic out_busy;
      logic clr_last;
   } stat_type;
endpackage

// ===== rtl/plsp_ctrl.sv =====
// Sequencer of the port list parser.
`timescale 1ns / 1ps
module plsp_ctrl import plsp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_FRESH, S_PROC, S_BRD, S_BCHK, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_row = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take_in = 1'b1;
               state_in = S_PROC;
            end
         end
         S_FRESH: begin
            cmd.fresh = 1'b1;
            state_in  = S_PROC;
         end
         S_PROC: begin
            if (stat.is_func1) begin
               state_in = S_EMIT;
            end else if (stat.spec_ended) begin
               state_in = S_FRESH;
            end else if (!stat.is_sep) begin
               cmd.take_char = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.check = 1'b1;
               state_in  = stat.walk_go ? S_BRD : S_EMIT;
            end
         end
         S_BRD: begin
            cmd.bm_read = 1'b1;
            state_in    = S_BCHK;
         end
         S_BCHK: begin
            cmd.bm_update = 1'b1;
            state_in = (stat.bm_hit || stat.walk_last) ? S_EMIT : S_BRD;
         end
         S_EMIT: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               state_in = (stat.is_term && !stat.is_func1) ? S_CLEAR : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== rtl/plsp_dpath.sv =====
// Datapath of the port list parser: token registers, seen bitmap, port list.
`timescale 1ns / 1ps
module plsp_dpath import plsp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic                 req_func,
   input  logic [7:0]           req_ch,
   input  logic [LIST_AW-1:0]   req_index,
   input  logic                 csr_wr_en,
   input  logic [MAXP_W-1:0]    csr_wr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [3:0]           rsp_status,
   output logic [15:0]          rsp_port_count,
   output logic [15:0]          rsp_token_first,
   output logic [15:0]          rsp_token_last,
   output logic                 rsp_done_res,
   output logic [15:0]          rsp_entry_port
);
   // control state
   logic [MAXP_W-1:0]    max_ports_ff, max_ports_in;
   logic [ACC_W-1:0]     left_ff, left_in, right_ff, right_in;
   logic                 dash_ff, dash_in, das_ff, das_in, lwd_ff, lwd_in;
   logic [CNT_W-1:0]     chars_ff, chars_in, count_ff, count_in;
   logic [3:0]           err_ff, err_in;
   logic                 ended_ff, ended_in;
   logic [ROW_AW-1:0]    clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   // payload
   logic                 func_ff;
   logic [7:0]           ch_ff;
   logic [PORT_BITS-1:0] p_ff, p_in;
   logic [3:0]           o_status_ff;
   logic [15:0]          o_count_ff, o_first_ff, o_last_ff, o_entry_ff;
   logic                 o_done_ff;
   // memories
   logic [ROW_W-1:0]     bm_mem [2 ** ROW_AW];
   logic [ROW_W-1:0]     bm_q_ff;
   logic [15:0]          list_mem [LIST_DEPTH];
   logic [15:0]          list_q_ff;

   logic                 digit_ch, hit, sep, term, single_ok, range_ok;
   logic [PORT_BITS-1:0] target;
   logic [20:0]          acc_src, acc_mul;
   logic [3:0]           err_fin;
   logic                 tok_ok;
   logic [15:0]          first_v, last_v;

   assign digit_ch = (ch_ff >= CH_ZERO) && (ch_ff <= CH_NINE);
   assign sep      = (ch_ff == CH_COMMA) || (ch_ff == CH_NUL);
   assign term     = (ch_ff == CH_NUL);
   assign hit      = bm_q_ff[p_ff[ROW_BITS-1:0]];
   assign target   = dash_ff ? right_ff[PORT_BITS-1:0] : left_ff[PORT_BITS-1:0];

   // token checks ahead of the walk
   assign single_ok = (left_ff != '0) && !left_ff[PORT_BITS];
   assign range_ok  = !das_ff && !lwd_ff && !left_ff[PORT_BITS] && !right_ff[PORT_BITS]
                    && (left_ff != '0) && (right_ff != '0) && (left_ff <= right_ff);

   assign stat.is_func1   = func_ff;
   assign stat.is_sep     = sep;
   assign stat.is_term    = term;
   assign stat.spec_ended = ended_ff;
   assign stat.walk_go    = (err_ff == ST_OK) && (chars_ff != '0)
                          && (dash_ff ? range_ok : single_ok);
   assign stat.bm_hit     = hit;
   assign stat.walk_last  = (p_ff == target);
   assign stat.out_busy   = rsp_valid_ff && rsp_stall;
   assign stat.clr_last   = (clr_ff == {ROW_AW{1'b1}});

   // decimal accumulate, saturating one past the largest port
   assign acc_src = 21'(dash_ff ? right_ff : left_ff);
   always_comb begin
      acc_mul = (acc_src << 3) + (acc_src << 1) + 21'(ch_ff - CH_ZERO);
      if (acc_mul > 21'(ACC_SAT)) acc_mul = 21'(ACC_SAT);
   end

   // result fields at emit
   assign err_fin = (term && (err_ff == ST_OK) && (count_ff > CNT_W'(max_ports_ff)))
                  ? ST_TOO_MANY : err_ff;
   assign tok_ok  = (err_fin == ST_OK);
   assign first_v = tok_ok ? left_ff[15:0] : 16'd0;
   assign last_v  = tok_ok ? target : 16'd0;

   // next state of token and spec registers
   always_comb begin
      max_ports_in = csr_wr_en ? csr_wr_data : max_ports_ff;
      left_in  = left_ff;  right_in = right_ff;
      dash_in  = dash_ff;  das_in   = das_ff;   lwd_in = lwd_ff;
      chars_in = chars_ff; count_in = count_ff; err_in = err_ff;
      ended_in = ended_ff; p_in     = p_ff;
      clr_in   = cmd.clr_row ? clr_ff + 1'b1 : clr_ff;
      rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);
      if (cmd.fresh) begin
         left_in = '0; right_in = '0; dash_in = 1'b0; das_in = 1'b0; lwd_in = 1'b0;
         chars_in = '0; err_in = ST_OK; count_in = '0; ended_in = 1'b0;
      end
      if (cmd.take_char && (err_ff == ST_OK)) begin
         if (ch_ff == CH_DASH) begin
            if (dash_ff) begin
               err_in = ST_TWO_DASH;
            end else begin
               dash_in = 1'b1;
               das_in  = (chars_ff == '0);
            end
            lwd_in = 1'b1;
         end else if (digit_ch) begin
            if (dash_ff) right_in = acc_mul[ACC_W-1:0];
            else         left_in  = acc_mul[ACC_W-1:0];
            lwd_in = 1'b0;
         end else begin
            err_in = ST_BAD_CHAR;
         end
         if (chars_ff != '1) chars_in = chars_ff + 1'b1;
      end
      if (cmd.check) begin
         p_in = left_ff[PORT_BITS-1:0];
         if (err_ff == ST_OK) begin
            if (chars_ff == '0)                         err_in = ST_EMPTY;
            else if (!dash_ff) begin
               if (left_ff == '0)                       err_in = ST_ZERO;
               else if (left_ff[PORT_BITS])             err_in = ST_OVER;
            end else begin
               if (das_ff || lwd_ff)                    err_in = ST_EDGE;
               else if (left_ff[PORT_BITS] || right_ff[PORT_BITS]) err_in = ST_OVER;
               else if (left_ff == '0 || right_ff == '0) err_in = ST_ZERO;
               else if (left_ff > right_ff)            err_in = ST_BACKWARD;
            end
         end
      end
      if (cmd.bm_update) begin
         if (hit) begin
            if (err_ff == ST_OK) err_in = ST_DUP;
         end else begin
            if (count_ff != '1) count_in = count_ff + 1'b1;
            p_in = p_ff + 1'b1;
         end
      end
      if (cmd.emit) begin
         clr_in = '0;
         if (!func_ff) begin
            left_in = '0; right_in = '0; dash_in = 1'b0; das_in = 1'b0;
            lwd_in = 1'b0; chars_in = '0;
            if (term) begin
               err_in   = err_fin;
               ended_in = 1'b1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ports_ff <= MAXP_W'(LIST_DEPTH);
         left_ff <= '0; right_ff <= '0; dash_ff <= 1'b0; das_ff <= 1'b0; lwd_ff <= 1'b0;
         chars_ff <= '0; count_ff <= '0; err_ff <= ST_OK; ended_ff <= 1'b0;
         clr_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         max_ports_ff <= max_ports_in;
         left_ff <= left_in; right_ff <= right_in; dash_ff <= dash_in;
         das_ff <= das_in; lwd_ff <= lwd_in;
         chars_ff <= chars_in; count_ff <= count_in; err_ff <= err_in;
         ended_ff <= ended_in; clr_ff <= clr_in; rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input word and walk pointer
   always_ff @(posedge clock) begin
      p_ff <= p_in;
      if (cmd.take_in) begin
         func_ff <= req_func;
         ch_ff   <= req_ch;
      end
   end

   // seen bitmap: clearing sweep or read-modify-write of one row
   always_ff @(posedge clock) begin
      if (cmd.clr_row) begin
         bm_mem[clr_ff] <= '0;
      end else if (cmd.bm_update && !hit) begin
         bm_mem[p_ff[PORT_BITS-1:ROW_BITS]] <= bm_q_ff | (ROW_W'(1) << p_ff[ROW_BITS-1:0]);
      end
      if (cmd.bm_read) bm_q_ff <= bm_mem[p_ff[PORT_BITS-1:ROW_BITS]];
   end

   // ordered port list
   always_ff @(posedge clock) begin
      if (cmd.bm_update && !hit && (count_ff < CNT_W'(LIST_DEPTH))) begin
         list_mem[count_ff[LIST_AW-1:0]] <= p_ff;
      end
      if (cmd.take_in && req_func) list_q_ff <= list_mem[req_index];
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         o_count_ff <= count_ff;
         if (func_ff) begin
            o_status_ff <= err_ff;
            o_first_ff  <= 16'd0;
            o_last_ff   <= 16'd0;
            o_done_ff   <= ended_ff;
            o_entry_ff  <= list_q_ff;
         end else begin
            o_status_ff <= err_fin;
            o_first_ff  <= first_v;
            o_last_ff   <= last_v;
            o_done_ff   <= term;
            o_entry_ff  <= 16'd0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = o_status_ff;
   assign rsp_port_count  = o_count_ff;
   assign rsp_token_first = o_first_ff;
   assign rsp_token_last  = o_last_ff;
   assign rsp_done_res    = o_done_ff;
   assign rsp_entry_port  = o_entry_ff;
endmodule

// ===== rtl/port_list_spec_parser_top.sv =====
// Top level of the port list specification parser.
`timescale 1ns / 1ps
// Takes a port list such as "22,80,1000-1010" one character word at a time, ended by a
// zero byte, and answers each comma, the terminator and each list read with one result word.
// The first character of a new list first clears the list state. A comma or terminator
// walks the span of its token through the seen bitmap (1024 rows of 64 bits, one bit per
// port), reading and writing one row per port, until a port already seen ends the walk.
// After reset and after each terminator all 1024 rows of the bitmap are swept clear, one
// row a cycle, during which no input word is taken.
module port_list_spec_parser_top import plsp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [7:0]         req_ch,
   input  logic [LIST_AW-1:0] req_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_status,
   output logic [15:0]        rsp_port_count,
   output logic [15:0]        rsp_token_first,
   output logic [15:0]        rsp_token_last,
   output logic               rsp_done_res,
   output logic [15:0]        rsp_entry_port,
   input  logic               csr_wr_en,
   input  logic [MAXP_W-1:0]  csr_wr_data
);
   cmd_type  cmd;
   stat_type stat;

   plsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   plsp_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_func),
      .req_ch          (req_ch),
      .req_index       (req_index),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_port_count  (rsp_port_count),
      .rsp_token_first (rsp_token_first),
      .rsp_token_last  (rsp_token_last),
      .rsp_done_res    (rsp_done_res),
      .rsp_entry_port  (rsp_entry_port)
   );
endmodule

// ===== rtl/plsp_checker.sv =====
// Port-level checks of the port list parser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plsp_checker import plsp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_status,
   input logic [15:0] rsp_token_first,
   input logic [15:0] rsp_token_last
);
   logic err_shown, span_zero;

   assign err_shown = rsp_valid && (rsp_status != ST_OK);
   assign span_zero = (rsp_token_first == 16'd0) && (rsp_token_last == 16'd0);

   // a stalled result word stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // a failed list shows no token span
   `ASSERT_IMPL(a_err_no_span, clock, reset, err_shown, span_zero)
   // status codes stop at too-many
   `ASSERT_IMPL(a_status_range, clock, reset, rsp_valid, rsp_status <= ST_TOO_MANY)
   // a reported span never runs backwards
   `ASSERT_IMPL(a_span_order, clock, reset, rsp_valid, rsp_token_first <= rsp_token_last)
endmodule

bind port_list_spec_parser_top plsp_checker u_plsp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_token_first (rsp_token_first),
   .rsp_token_last  (rsp_token_last)
);
